FILE: rtl/core/four_voice_waveform_mixer_assert.svh
// Assertion macros used by the mixer top level.
`ifndef FOUR_VOICE_WAVEFORM_MIXER_ASSERT_SVH
`define FOUR_VOICE_WAVEFORM_MIXER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FVM_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mixer check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define FVM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mixer check failed");

`endif

FILE: rtl/core/fvm_pkg.sv
// Types and constants shared by the four-voice mixer modules.
`default_nettype none
package fvm_pkg;

	localparam int VOICE_W  = 2;
	localparam int TGT_W    = 2;
	localparam int VALUE_W  = 16;
	localparam int PHASE_W  = 16;
	localparam int WAVE_W   = 8;
	localparam int VOL_W    = 8;
	localparam int LVL_W    = 6;
	localparam int PROD_W   = 14;
	localparam int ACC_W    = 16;
	localparam int SAMPLE_W = 8;
	localparam int SEED_W   = 32;

	localparam logic [SEED_W-1:0] SEED_RESET = 32'h0000_0001;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	localparam logic [TGT_W-1:0] TGT_FREQ   = 2'd0;
	localparam logic [TGT_W-1:0] TGT_DUTY   = 2'd1;
	localparam logic [TGT_W-1:0] TGT_WAVE   = 2'd2;
	localparam logic [TGT_W-1:0] TGT_VOLUME = 2'd3;

	localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 8'd0;
	localparam logic [WAVE_W-1:0] WAVE_SAW      = 8'd1;
	localparam logic [WAVE_W-1:0] WAVE_PULSE    = 8'd2;
	localparam logic [WAVE_W-1:0] WAVE_NOISE    = 8'd3;

	localparam logic signed [LVL_W-1:0] LVL_LOW  = -6'sd32;
	localparam logic signed [LVL_W-1:0] LVL_HIGH = 6'sd31;
	localparam logic signed [LVL_W-1:0] LVL_ZERO = 6'sd0;

	typedef struct packed {
		logic               tick;
		logic               wr;
		logic [TGT_W-1:0]   target;
		logic [VALUE_W-1:0] value;
	} voice_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/core/fvm_noise.sv
// 32-bit noise LFSR with taps 31, 24, 9 and 6.
`default_nettype none
module fvm_noise (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         step,
	output logic      [fvm_pkg::LVL_W-1:0]    noise
);

	logic [fvm_pkg::SEED_W-1:0] seed_q;
	logic [fvm_pkg::SEED_W-1:0] seed_next;

	assign seed_next = {seed_q[fvm_pkg::SEED_W-2:0],
		seed_q[31] ^ seed_q[24] ^ seed_q[9] ^ seed_q[6]};

	// Voices see the seed after this tick's step.
	assign noise = seed_next[fvm_pkg::LVL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= fvm_pkg::SEED_RESET;
		end else if (step) begin
			seed_q <= seed_next;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/fvm_voice.sv
// One voice: its settings, its phase accumulator and its scaled level.
`default_nettype none
module fvm_voice (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire fvm_pkg::voice_ctl_t               ctl,
	input  wire logic        [fvm_pkg::LVL_W-1:0]  noise,
	output logic signed      [fvm_pkg::PROD_W-1:0] product
);

	logic [fvm_pkg::PHASE_W-1:0] phase_q;
	logic [fvm_pkg::VALUE_W-1:0] freq_q;
	logic [fvm_pkg::VALUE_W-1:0] duty_q;
	logic [fvm_pkg::WAVE_W-1:0]  wave_q;
	logic [fvm_pkg::VOL_W-1:0]   vol_q;

	logic signed [fvm_pkg::LVL_W-1:0]  level;
	logic signed [fvm_pkg::PROD_W-1:0] level_ext;
	logic signed [fvm_pkg::PROD_W-1:0] vol_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			freq_q  <= '0;
			duty_q  <= '0;
			wave_q  <= fvm_pkg::WAVE_TRIANGLE;
			vol_q   <= '0;
		end else begin
			if (ctl.tick) begin
				phase_q <= phase_q + freq_q;
			end
			if (ctl.wr) begin
				unique case (ctl.target)
					fvm_pkg::TGT_FREQ:   freq_q <= ctl.value;
					fvm_pkg::TGT_DUTY:   duty_q <= ctl.value;
					fvm_pkg::TGT_WAVE:   wave_q <= ctl.value[fvm_pkg::WAVE_W-1:0];
					fvm_pkg::TGT_VOLUME: vol_q  <= ctl.value[fvm_pkg::VOL_W-1:0];
				endcase
			end
		end
	end

	// Adding -32 to a 6-bit count is the same as flipping its top bit, and
	// 31 minus a 6-bit count keeps the top bit and inverts the rest.
	always_comb begin
		case (wave_q)
			fvm_pkg::WAVE_TRIANGLE: begin
				if (!phase_q[15]) begin
					level = {~phase_q[14], phase_q[13:9]};
				end else begin
					level = {phase_q[14], ~phase_q[13:9]};
				end
			end
			fvm_pkg::WAVE_SAW:   level = {~phase_q[15], phase_q[14:10]};
			fvm_pkg::WAVE_PULSE: level = (phase_q > duty_q) ? fvm_pkg::LVL_LOW
				: fvm_pkg::LVL_HIGH;
			fvm_pkg::WAVE_NOISE: level = {~noise[5], noise[4:0]};
			default:             level = fvm_pkg::LVL_ZERO;
		endcase
	end

	assign level_ext = fvm_pkg::PROD_W'(level);
	assign vol_ext   = fvm_pkg::PROD_W'($signed({1'b0, vol_q}));
	assign product   = level_ext * vol_ext;

endmodule
`default_nettype wire

FILE: rtl/core/four_voice_waveform_mixer.sv
// Four-voice waveform mixer: a request either writes one voice setting
// (frequency, duty, waveform or volume) or is a sample tick that steps the
// noise LFSR, mixes all voices into one unsigned 8-bit sample (128 is
// silence) and advances every voice's phase. Requests go into an input
// register and are worked off from there; a new request can be taken
// every cycle, and a finished sample waits in an output register while the
// next request is taken. A write produces no sample; each tick produces
// exactly one, loaded into the output register as the tick leaves the
// input register. Only a tick that finds the output register still full stalls.
`default_nettype none
`include "four_voice_waveform_mixer_assert.svh"
module four_voice_waveform_mixer #(
	parameter int VOICES = 4
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            req_valid,
	output logic                                 req_ready,
	input  wire logic                            command,
	input  wire logic [fvm_pkg::VOICE_W-1:0]     voice,
	input  wire logic [fvm_pkg::TGT_W-1:0]       target,
	input  wire logic [fvm_pkg::VALUE_W-1:0]     value,
	output logic                                 sample_valid,
	input  wire logic                            sample_ready,
	output logic      [fvm_pkg::SAMPLE_W-1:0]    sample
);

	logic                         valid_s1;
	logic                         command_s1;
	logic [fvm_pkg::VOICE_W-1:0]  voice_s1;
	logic [fvm_pkg::TGT_W-1:0]    target_s1;
	logic [fvm_pkg::VALUE_W-1:0]  value_s1;

	logic                         sample_valid_q;
	logic [fvm_pkg::SAMPLE_W-1:0] sample_q;

	logic advance;
	logic tick_en;
	logic wr_en;

	logic [fvm_pkg::LVL_W-1:0]          noise;
	logic signed [fvm_pkg::PROD_W-1:0]  product [VOICES];
	logic signed [fvm_pkg::ACC_W-1:0]   acc;
	logic [fvm_pkg::SAMPLE_W-1:0]       sample_d;

	// A write always moves on; a tick needs room in the output register.
	assign advance   = valid_s1 && (command_s1 == fvm_pkg::CMD_WRITE ||
		!sample_valid_q || sample_ready);
	assign tick_en   = advance && command_s1 == fvm_pkg::CMD_TICK;
	assign wr_en     = advance && command_s1 == fvm_pkg::CMD_WRITE;
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			command_s1 <= command;
			voice_s1   <= voice;
			target_s1  <= target;
			value_s1   <= value;
		end
	end

	fvm_noise u_noise (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (tick_en),
		.noise  (noise)
	);

	for (genvar g = 0; g < VOICES; g++) begin : g_voice
		fvm_pkg::voice_ctl_t ctl;

		assign ctl.tick   = tick_en;
		assign ctl.wr     = wr_en && voice_s1 == fvm_pkg::VOICE_W'(g);
		assign ctl.target = target_s1;
		assign ctl.value  = value_s1;

		fvm_voice u_voice (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.noise   (noise),
			.product (product[g])
		);
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < VOICES; i++) begin
			acc = acc + fvm_pkg::ACC_W'(product[i]);
		end
	end

	// The sum never leaves the 16-bit signed range, so shifting right by 8
	// and adding 128 amounts to taking the high byte with its top bit flipped.
	assign sample_d = {~acc[fvm_pkg::ACC_W-1], acc[fvm_pkg::ACC_W-2:fvm_pkg::ACC_W-8]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid_q <= 1'b0;
		end else if (tick_en) begin
			sample_valid_q <= 1'b1;
		end else if (sample_ready) begin
			sample_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_en) begin
			sample_q <= sample_d;
		end
	end

	assign sample_valid = sample_valid_q;
	assign sample       = sample_q;

	`FVM_ASSERT_NEXT(a_tick_gives_sample, tick_en, sample_valid_q)
	`FVM_ASSERT_NEXT(a_no_sample_without_tick, !sample_valid_q && !tick_en, !sample_valid_q)
	`FVM_ASSERT_SAME(a_full_output_blocks_tick,
		valid_s1 && command_s1 == fvm_pkg::CMD_TICK && sample_valid_q && !sample_ready,
		!req_ready && !tick_en)

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the four-voice waveform mixer.
`timescale 1ns / 1ps

class mix_scoreboard;
	localparam int VOICE_COUNT = 4;

	bit [31:0] lfsr;
	bit [15:0] phase_acc[VOICE_COUNT];
	bit [15:0] step_size[VOICE_COUNT];
	bit [15:0] duty_mark[VOICE_COUNT];
	bit [7:0]  wave_sel[VOICE_COUNT];
	bit [7:0]  gain[VOICE_COUNT];
	bit [7:0]  samples_due[$];
	int        errors;
	int        ticks_seen;
	int        writes_seen;
	int        samples_checked;

	function new();
		lfsr = fvm_pkg::SEED_RESET;
		for (int i = 0; i < VOICE_COUNT; i++) begin
			phase_acc[i] = '0;
			step_size[i] = '0;
			duty_mark[i] = '0;
			wave_sel[i]  = fvm_pkg::WAVE_TRIANGLE;
			gain[i]      = '0;
		end
	endfunction

	task report(string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// Signed 6-bit level of one voice; the LFSR must already have stepped.
	function int wave_point(int v);
		int p;
		p = phase_acc[v];
		case (wave_sel[v])
			fvm_pkg::WAVE_TRIANGLE: begin
				if (p < 'h8000)
					return -32 + (p >> 9);
				return 31 - ((p - 'h8000) >> 9);
			end
			fvm_pkg::WAVE_SAW:   return -32 + (p >> 10);
			fvm_pkg::WAVE_PULSE: return (p > int'(duty_mark[v])) ? -32 : 31;
			fvm_pkg::WAVE_NOISE: return int'(lfsr[5:0]) - 32;
			default:             return 0;
		endcase
	endfunction

	function void note_request(logic cmd, logic [1:0] v, logic [1:0] tgt, logic [15:0] val);
		int        mix;
		bit [31:0] biased;
		if (cmd == fvm_pkg::CMD_WRITE) begin
			writes_seen++;
			if (v < VOICE_COUNT) begin
				case (tgt)
					fvm_pkg::TGT_FREQ: step_size[v] = val;
					fvm_pkg::TGT_DUTY: duty_mark[v] = val;
					fvm_pkg::TGT_WAVE: wave_sel[v]  = val[7:0];
					default:           gain[v]      = val[7:0];
				endcase
			end
			return;
		end
		ticks_seen++;
		lfsr = {lfsr[30:0], lfsr[31] ^ lfsr[24] ^ lfsr[9] ^ lfsr[6]};
		mix = 0;
		for (int i = 0; i < VOICE_COUNT; i++) begin
			mix += wave_point(i) * int'(gain[i]);
			phase_acc[i] = phase_acc[i] + step_size[i];
		end
		// Offsetting by 32768 turns the arithmetic shift into a plain one.
		biased = mix + 32768;
		samples_due.push_back(biased[15:8]);
	endfunction

	task check_sample(logic [7:0] got);
		bit [7:0] want;
		if (samples_due.size() == 0) begin
			report($sformatf("sample %0d arrived with none outstanding", got));
			return;
		end
		want = samples_due.pop_front();
		samples_checked++;
		if (got !== want)
			report($sformatf("sample #%0d: got %0d, expected %0d",
				samples_checked, got, want));
	endtask

	task flush_check();
		if (samples_due.size() != 0)
			report($sformatf("%0d samples never arrived", samples_due.size()));
	endtask
endclass

module tb_top;

	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_REQS = 930;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	logic        command = fvm_pkg::CMD_TICK;
	logic [1:0]  voice = '0;
	logic [1:0]  target = fvm_pkg::TGT_FREQ;
	logic [15:0] value = '0;
	logic        sample_valid;
	logic        sample_ready = 1'b0;
	logic [7:0]  sample;

	bit            idle_on = 1'b1;
	int            stall_cycles = 0;
	mix_scoreboard sb = new();

	four_voice_waveform_mixer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.command      (command),
		.voice        (voice),
		.target       (target),
		.value        (value),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (arst_n)
			sample_ready <= !(idle_on && $urandom_range(99) < 11);
	end

	always @(posedge clk) begin
		if (arst_n && sample_valid && sample_ready)
			sb.check_sample(sample);
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (sample_valid && sample_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles == STALL_LIMIT) begin
			$display("Timeout: no request or sample moved for %0d cycles", STALL_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task send_request(logic cmd, logic [1:0] v, logic [1:0] tgt, logic [15:0] val);
		if (idle_on && $urandom_range(99) < 11) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		req_valid <= 1'b1;
		command   <= cmd;
		voice     <= v;
		target    <= tgt;
		value     <= val;
		do
			@(posedge clk);
		while (!req_ready);
		sb.note_request(cmd, v, tgt, val);
		@(negedge clk);
	endtask

	task write_setting(logic [1:0] v, logic [1:0] tgt, logic [15:0] val);
		send_request(fvm_pkg::CMD_WRITE, v, tgt, val);
	endtask

	task tick();
		send_request(fvm_pkg::CMD_TICK, 2'($urandom_range(3)), 2'($urandom_range(3)),
			16'($urandom()));
	endtask

	task wait_drained();
		req_valid <= 1'b0;
		do
			@(negedge clk);
		while (sb.samples_due.size() != 0);
	endtask

	task random_request();
		logic [1:0]  tgt;
		logic [15:0] val;
		if ($urandom_range(99) < 55) begin
			tick();
			return;
		end
		tgt = 2'($urandom_range(3));
		val = 16'($urandom());
		// Keep most waveform writes on the four defined shapes.
		if (tgt == fvm_pkg::TGT_WAVE && $urandom_range(99) < 85)
			val[7:0] = 8'($urandom_range(3));
		else if (tgt == fvm_pkg::TGT_FREQ && $urandom_range(99) < 30)
			val = 16'($urandom_range(1023));
		write_setting(2'($urandom_range(3)), tgt, val);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Silence first, then the triangle alone, then all four shapes mixed.
		tick();
		write_setting(2'd0, fvm_pkg::TGT_FREQ, 16'hFFFF);
		write_setting(2'd0, fvm_pkg::TGT_VOLUME, 16'h00FF);
		tick();
		tick();
		write_setting(2'd1, fvm_pkg::TGT_WAVE, {8'h00, fvm_pkg::WAVE_SAW});
		write_setting(2'd1, fvm_pkg::TGT_VOLUME, 16'hFFFF);
		write_setting(2'd1, fvm_pkg::TGT_FREQ, 16'h8000);
		write_setting(2'd2, fvm_pkg::TGT_WAVE, {8'hA5, fvm_pkg::WAVE_PULSE});
		write_setting(2'd2, fvm_pkg::TGT_DUTY, 16'h8000);
		write_setting(2'd2, fvm_pkg::TGT_FREQ, 16'h4000);
		write_setting(2'd2, fvm_pkg::TGT_VOLUME, 16'h00FF);
		write_setting(2'd3, fvm_pkg::TGT_WAVE, {8'hFF, fvm_pkg::WAVE_NOISE});
		write_setting(2'd3, fvm_pkg::TGT_VOLUME, 16'h0080);
		tick();
		tick();
		tick();
		// Selectors past the defined shapes must contribute nothing.
		write_setting(2'd0, fvm_pkg::TGT_WAVE, 16'h0004);
		tick();
		write_setting(2'd1, fvm_pkg::TGT_WAVE, 16'hFFFF);
		write_setting(2'd2, fvm_pkg::TGT_DUTY, 16'hFFFF);
		tick();
		write_setting(2'd3, fvm_pkg::TGT_DUTY, 16'h0000);
		tick();

		for (int n = 0; n < RANDOM_REQS; n++) begin
			idle_on = !(n >= 450 && n < 650);
			if (n == 300 || n == 700)
				wait_drained();
			random_request();
		end

		wait_drained();
		repeat (8) @(posedge clk);
		sb.flush_check();
		$display("Covered %0d requests: %0d sample ticks and %0d voice setting writes.",
			sb.ticks_seen + sb.writes_seen, sb.ticks_seen, sb.writes_seen);
		$display("Checked %0d samples with %0d mismatches.", sb.samples_checked, sb.errors);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
